/* src/erhc_pkg.sv */
// ----------------------------------------------------------------------------
// erhc_pkg: shared types and constants of the error record header checker
// Beat layouts, verdict codes, sequencer phases and record geometry.
// ----------------------------------------------------------------------------
package erhc_pkg;

  // Record geometry in bytes
  localparam int unsigned HEADER_BYTES     = 128;
  localparam int unsigned DESCRIPTOR_BYTES = 72;

  localparam int unsigned SEC_W = 16;
  localparam int unsigned WORD_W = 32;

  // Largest end of the descriptor table, and the bits it needs
  localparam longint unsigned TABLE_END_MAX =
    longint'(HEADER_BYTES) + longint'(DESCRIPTOR_BYTES) * ((longint'(1) << SEC_W) - 1);
  localparam int unsigned TABLE_W = $clog2(TABLE_END_MAX + 1);

  localparam logic [WORD_W-1:0] SIGNATURE_RESET = 32'h5245_5043;

  // Register indexes of the configuration port
  localparam logic REG_EXPECTED_SIG = 1'b0;

  typedef enum logic {
    OP_HEADER     = 1'b0,
    OP_DESCRIPTOR = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    PHASE_WAIT     = 2'd0,
    PHASE_SECTIONS = 2'd1
  } phase_e;

  typedef enum logic [3:0] {
    ERR_OK         = 4'd0,
    ERR_SHORT      = 4'd1,
    ERR_SIGNATURE  = 4'd2,
    ERR_LENGTH     = 4'd3,
    ERR_NO_ROOM    = 4'd4,
    ERR_GAP        = 4'd5,
    ERR_EMPTY      = 4'd6,
    ERR_OVERLAP    = 4'd7,
    ERR_OVERFLOW   = 4'd8,
    ERR_PAST_END   = 4'd9,
    ERR_TRAILING   = 4'd10,
    ERR_UNEXPECTED = 4'd11
  } err_e;

  // Input beat, last field in the lowest bits
  typedef struct packed {
    logic [WORD_W-1:0] section_length;
    logic [WORD_W-1:0] section_offset;
    logic [SEC_W-1:0]  section_count;
    logic [WORD_W-1:0] record_length;
    logic [WORD_W-1:0] signature;
    logic [WORD_W-1:0] buffer_size;
  } in_data_t;

  localparam int unsigned IN_DATA_W = $bits(in_data_t);

  typedef struct packed {
    op_e      opcode;
    in_data_t data;
  } in_beat_t;

  typedef struct packed {
    logic             verdict_ready;
    logic             record_valid;
    err_e             error_code;
    logic [SEC_W-1:0] failing_section;
  } result_t;

  localparam int unsigned OUT_DATA_W = 24;

endpackage

/* src/erhc_cfg.sv */
// ----------------------------------------------------------------------------
// erhc_cfg: configuration register file
// APB-style write/read port holding the expected record signature.
// ----------------------------------------------------------------------------
module erhc_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output logic [erhc_pkg::WORD_W-1:0] expected_sig_o
);
  import erhc_pkg::*;

  logic              wr_en;
  logic              reg_hit;
  logic [WORD_W-1:0] expected_sig_q;
  logic [WORD_W-1:0] expected_sig_d;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == REG_EXPECTED_SIG);
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    expected_sig_d = expected_sig_q;
    if (wr_en && reg_hit) begin
      expected_sig_d = pwdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_sig_q <= SIGNATURE_RESET;
    end else begin
      expected_sig_q <= expected_sig_d;
    end
  end

  assign prdata         = reg_hit ? expected_sig_q : '0;
  assign expected_sig_o = expected_sig_q;

endmodule

/* src/erhc_core.sv */
// ----------------------------------------------------------------------------
// erhc_core: record check sequencer
// Running record state and the single-pass header and descriptor checks.
// ----------------------------------------------------------------------------
module erhc_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        fire_i,
  input  erhc_pkg::in_beat_t          beat_i,
  input  logic [erhc_pkg::WORD_W-1:0] expected_sig_i,
  output erhc_pkg::result_t           result_o
);
  import erhc_pkg::*;

  phase_e             phase_q, phase_d;
  logic [WORD_W-1:0]  held_size_q, held_size_d;
  logic [WORD_W-1:0]  running_end_q, running_end_d;
  logic [SEC_W-1:0]   sections_left_q, sections_left_d;
  logic [SEC_W-1:0]   section_number_q, section_number_d;

  // Header checks
  logic [TABLE_W-1:0] table_end;
  logic [WORD_W-1:0]  table_end_w;
  logic               h_short, h_sig, h_len, h_room, h_ok, h_trail, h_none;

  // Descriptor checks
  logic [SEC_W-1:0]   sec_n;
  logic [TABLE_W-1:0] own_end;
  logic [WORD_W:0]    sum;
  logic [SEC_W-1:0]   left_next;
  logic               d_gap, d_empty, d_overlap, d_ovf, d_past, d_ok, d_last, d_trail;
  logic               is_hdr;

  assign is_hdr = (beat_i.opcode == OP_HEADER);

  assign table_end   = TABLE_W'(HEADER_BYTES)
                     + TABLE_W'(DESCRIPTOR_BYTES) * TABLE_W'(beat_i.data.section_count);
  assign table_end_w = WORD_W'(table_end);
  assign h_short = beat_i.data.buffer_size < WORD_W'(HEADER_BYTES);
  assign h_sig   = beat_i.data.signature != expected_sig_i;
  assign h_len   = beat_i.data.buffer_size != beat_i.data.record_length;
  assign h_room  = beat_i.data.buffer_size < table_end_w;
  assign h_ok    = !h_short && !h_sig && !h_len && !h_room;
  assign h_trail = beat_i.data.buffer_size != table_end_w;
  assign h_none  = (beat_i.data.section_count == '0);

  assign sec_n     = section_number_q + SEC_W'(1);
  assign own_end   = TABLE_W'(HEADER_BYTES) + TABLE_W'(DESCRIPTOR_BYTES) * TABLE_W'(sec_n);
  assign sum       = {1'b0, beat_i.data.section_offset} + {1'b0, beat_i.data.section_length};
  assign d_gap     = beat_i.data.section_offset != running_end_q;
  assign d_empty   = (beat_i.data.section_length == '0);
  assign d_overlap = beat_i.data.section_offset < WORD_W'(own_end);
  assign d_ovf     = sum[WORD_W];
  assign d_past    = sum[WORD_W-1:0] > held_size_q;
  assign d_ok      = !d_gap && !d_empty && !d_overlap && !d_ovf && !d_past;
  assign left_next = sections_left_q - SEC_W'(1);
  assign d_last    = (left_next == '0);
  assign d_trail   = held_size_q != sum[WORD_W-1:0];

  // Verdict for the current beat
  always_comb begin
    result_o = '{verdict_ready: 1'b1, record_valid: 1'b0,
                 error_code: ERR_OK, failing_section: '0};
    if (is_hdr) begin
      if (h_short) begin
        result_o.error_code = ERR_SHORT;
      end else if (h_sig) begin
        result_o.error_code = ERR_SIGNATURE;
      end else if (h_len) begin
        result_o.error_code = ERR_LENGTH;
      end else if (h_room) begin
        result_o.error_code = ERR_NO_ROOM;
      end else if (!h_none) begin
        result_o.verdict_ready = 1'b0;
      end else if (h_trail) begin
        result_o.error_code = ERR_TRAILING;
      end else begin
        result_o.record_valid = 1'b1;
      end
    end else begin
      case (phase_q)
        PHASE_SECTIONS: begin
          result_o.failing_section = sec_n;
          if (d_gap) begin
            result_o.error_code = ERR_GAP;
          end else if (d_empty) begin
            result_o.error_code = ERR_EMPTY;
          end else if (d_overlap) begin
            result_o.error_code = ERR_OVERLAP;
          end else if (d_ovf) begin
            result_o.error_code = ERR_OVERFLOW;
          end else if (d_past) begin
            result_o.error_code = ERR_PAST_END;
          end else begin
            result_o.failing_section = '0;
            if (!d_last) begin
              result_o.verdict_ready = 1'b0;
            end else if (d_trail) begin
              result_o.error_code = ERR_TRAILING;
            end else begin
              result_o.record_valid = 1'b1;
            end
          end
        end
        default: begin
          result_o.error_code = ERR_UNEXPECTED;
        end
      endcase
    end
  end

  // Next state
  always_comb begin
    phase_d          = phase_q;
    held_size_d      = held_size_q;
    running_end_d    = running_end_q;
    sections_left_d  = sections_left_q;
    section_number_d = section_number_q;
    if (fire_i) begin
      if (is_hdr) begin
        held_size_d      = beat_i.data.buffer_size;
        section_number_d = '0;
        sections_left_d  = '0;
        running_end_d    = h_ok ? table_end_w : '0;
        phase_d          = PHASE_WAIT;
        if (h_ok && !h_none) begin
          sections_left_d = beat_i.data.section_count;
          phase_d         = PHASE_SECTIONS;
        end
      end else begin
        case (phase_q)
          PHASE_SECTIONS: begin
            section_number_d = sec_n;
            if (d_ok) begin
              running_end_d   = sum[WORD_W-1:0];
              sections_left_d = left_next;
              if (d_last) begin
                phase_d = PHASE_WAIT;
              end
            end else begin
              phase_d = PHASE_WAIT;
            end
          end
          default: begin
            phase_d = PHASE_WAIT;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q          <= PHASE_WAIT;
      held_size_q      <= '0;
      running_end_q    <= '0;
      sections_left_q  <= '0;
      section_number_q <= '0;
    end else begin
      phase_q          <= phase_d;
      held_size_q      <= held_size_d;
      running_end_q    <= running_end_d;
      sections_left_q  <= sections_left_d;
      section_number_q <= section_number_d;
    end
  end

  // A passed record must be a final verdict with no error
  a_valid_is_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.record_valid |-> (result_o.verdict_ready && result_o.error_code == ERR_OK))
    else $error("record_valid without a clean final verdict");

  // A passing descriptor that is not the last keeps the record open
  a_open_record: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && !is_hdr && phase_q == PHASE_SECTIONS && d_ok && !d_last)
      |=> (phase_q == PHASE_SECTIONS))
    else $error("record closed early");

  // A final verdict always returns the sequencer to waiting for a header
  a_final_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && result_o.verdict_ready) |=> (phase_q == PHASE_WAIT))
    else $error("final verdict left the record open");

endmodule

/* src/error_record_header_checker_top.sv */
// ----------------------------------------------------------------------------
// error_record_header_checker_top: platform error record header checker
// Streams a header beat and its section descriptor beats, returns one verdict
// beat per input beat.
// ----------------------------------------------------------------------------
// Send one header beat (tuser low) followed by one descriptor beat per
// announced section (tuser high). Every input beat produces exactly one
// output beat: tlast high marks the final verdict of a record, with
// record_valid set only when every check passed; tlast low is a running
// "so far so good". A header beat arriving mid-record abandons the record in
// progress without a verdict and starts a new one. The block takes one beat
// per clock while the output is not stalled; an accepted beat passes through
// the input register and then the result register before its verdict is
// returned. The only combinational path between the two streams is
// m_axis_tready to s_axis_tready, which lets a full pipeline keep moving while
// the downstream side drains. Write the expected signature only while no beat is in flight.
module error_record_header_checker_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata from bit 0: buffer_size[31:0], signature[63:32],
  // record_length[95:64], section_count[111:96], section_offset[143:112],
  // section_length[175:144]
  input  logic [erhc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: opcode (0 header, 1 section descriptor)
  input  logic                            s_axis_tuser,
  // Output stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tdata from bit 0: record_valid[0], error_code[4:1],
  // failing_section[20:5], zero[23:21]
  output logic [erhc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // tlast: verdict_ready
  output logic                            m_axis_tlast,
  // Configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [2:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import erhc_pkg::*;

  logic              in_valid_q, in_valid_d;
  in_beat_t          in_beat_q;
  logic              out_valid_q, out_valid_d;
  result_t           out_res_q;
  result_t           core_res;
  logic              advance;
  logic              in_take;
  logic [WORD_W-1:0] expected_sig;

  erhc_cfg u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .expected_sig_o (expected_sig)
  );

  // Move the held beat into the result register when that slot frees up
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  erhc_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (advance),
    .beat_i         (in_beat_q),
    .expected_sig_i (expected_sig),
    .result_o       (core_res)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: load on their beat, hold otherwise
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_beat_q <= '{opcode: op_e'(s_axis_tuser), data: in_data_t'(s_axis_tdata)};
    end
    if (advance) begin
      out_res_q <= core_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_res_q.verdict_ready;
  assign m_axis_tdata  = {3'b000, out_res_q.failing_section,
                          out_res_q.error_code, out_res_q.record_valid};

  // An accepted beat is held in the input register next cycle
  a_take_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> in_valid_q)
    else $error("accepted beat lost");

  // Moving a beat on always fills the result register
  a_advance_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("result dropped");

  // A waiting result is never overwritten while the output is stalled
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |-> !advance)
    else $error("stalled result overwritten");

endmodule
